@@ hdl/mv4_pkg.sv @@
// ----------------------------------------------------------------------------
// mv4_pkg: shared types and helpers for the 4x4 single-precision transform
// Unpacked number formats, single unpack, exact product and leading-zero count.
// ----------------------------------------------------------------------------
package mv4_pkg;

  // matrix register count and canonical quiet nan
  localparam int unsigned CfgPairs = 8;
  localparam logic [31:0] QNAN     = 32'h7FC0_0000;

  // unpacked single: value = man * 2^(exp-23), man[23] set when finite non-zero
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sign;
    logic signed [9:0]  exp;
    logic [23:0]        man;
  } snum_t;

  // unpacked double: value = man * 2^(exp-52), man[52] set when finite non-zero
  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sign;
    logic signed [11:0] exp;
    logic [52:0]        man;
  } dnum_t;

  // unpack a single bit pattern, normalising denormals
  function automatic snum_t sp_unpack(input logic [31:0] b);
    snum_t       r;
    logic [7:0]  e;
    logic [22:0] f;
    logic [4:0]  s;
    e = b[30:23];
    f = b[22:0];
    r = '0;
    r.sign = b[31];
    s = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (f[i]) s = 5'(22 - i);
    end
    if (e == 8'hFF) begin
      r.nan = (f != 23'd0);
      r.inf = (f == 23'd0);
    end else if (e == 8'd0) begin
      if (f == 23'd0) begin
        r.zero = 1'b1;
      end else begin
        r.man = 24'({1'b0, f} << (s + 5'd1));
        r.exp = -10'sd127 - $signed({5'd0, s});
      end
    end else begin
      r.man = {1'b1, f};
      r.exp = $signed({2'b00, e}) - 10'sd127;
    end
    return r;
  endfunction

  // exact product of two unpacked singles as an unpacked double
  function automatic dnum_t dp_mul(input snum_t a, input snum_t b);
    dnum_t              r;
    logic [47:0]        p;
    logic signed [11:0] es;
    p  = a.man * b.man;
    es = 12'(a.exp) + 12'(b.exp);
    r  = '0;
    r.sign = a.sign ^ b.sign;
    if (a.nan || b.nan || (a.inf && b.zero) || (a.zero && b.inf)) begin
      r.nan = 1'b1;
    end else if (a.inf || b.inf) begin
      r.inf = 1'b1;
    end else if (a.zero || b.zero) begin
      r.zero = 1'b1;
    end else if (p[47]) begin
      r.man = {p, 5'd0};
      r.exp = es + 12'sd1;
    end else begin
      r.man = {p[46:0], 6'd0};
      r.exp = es;
    end
    return r;
  endfunction

  // leading zeros of a 56-bit word
  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    n = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (v[i]) n = 6'(55 - i);
    end
    return n;
  endfunction

endpackage

@@ hdl/fp32_matrix_vector4_transform.sv @@
// ----------------------------------------------------------------------------
// fp32_matrix_vector4_transform: 4x4 single-precision matrix times vector
// Column-major matrix in configuration, exact double products, double sums.
// ----------------------------------------------------------------------------
// One vector is taken per clock unless the pipeline holds, and its result is
// offered from the last of 19 register stages: one stage unpacks the operands,
// one forms the sixteen exact products, three five-stage double adders in
// series build each row sum left to right, and two stages round the sum to
// single. The whole pipeline advances together and holds when the result
// register is full and not taken, so in_ready is low only then. Any nan
// result is returned as 0x7FC00000. Matrix registers should be written
// only while no vector is in flight.
module fp32_matrix_vector4_transform
  import mv4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] vec_0,
  input  logic [31:0] vec_1,
  input  logic [31:0] vec_2,
  input  logic [31:0] vec_3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_0,
  output logic [31:0] out_1,
  output logic [31:0] out_2,
  output logic [31:0] out_3
);

  localparam int unsigned NStage = 19;

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sign;
    logic signed [11:0] se;
    logic [23:0]        q;
    logic               g;
    logic               st;
  } nar_t;

  // matrix registers
  logic [63:0] mat_pair [CfgPairs];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CfgPairs; k++) mat_pair[k] <= 64'd0;
    end else if (cfg_valid && (cfg_index < 8'(CfgPairs))) begin
      mat_pair[cfg_index[2:0]] <= cfg_data;
    end
  end

  // pipeline advance and valid bits
  logic              en;
  logic [NStage-1:0] vld;

  assign en        = !vld[NStage-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NStage-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NStage-2:0], in_valid};
    end
  end

  // stage 1: unpack vector and matrix
  logic [31:0] vin [4];
  snum_t       vu  [4];
  snum_t       mu  [16];

  assign vin[0] = vec_0;
  assign vin[1] = vec_1;
  assign vin[2] = vec_2;
  assign vin[3] = vec_3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) vu[c] <= sp_unpack(vin[c]);
      for (int k = 0; k < 16; k++) begin
        mu[k] <= sp_unpack((k % 2 == 1) ? mat_pair[k / 2][63:32] : mat_pair[k / 2][31:0]);
      end
    end
  end

  // stage 2: exact products, entry r+4c times element c
  dnum_t prod [16];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 16; k++) prod[k] <= dp_mul(mu[k], vu[k / 4]);
    end
  end

  // row sums and rounding to single
  logic [31:0] res [4];

  for (genvar r = 0; r < 4; r++) begin : g_row
    dnum_t dl2 [5];
    dnum_t dl3 [10];
    dnum_t s0;
    dnum_t s1;
    dnum_t s2;

    // hold the later products until the running sum catches up
    always_ff @(posedge clk) begin
      if (en) begin
        dl2[0] <= prod[r + 8];
        dl3[0] <= prod[r + 12];
        for (int i = 1; i < 5; i++) dl2[i] <= dl2[i-1];
        for (int i = 1; i < 10; i++) dl3[i] <= dl3[i-1];
      end
    end

    mv4_dadd u_add0 (.clk(clk), .en(en), .a(prod[r]), .b(prod[r + 4]), .y(s0));
    mv4_dadd u_add1 (.clk(clk), .en(en), .a(s0), .b(dl2[4]), .y(s1));
    mv4_dadd u_add2 (.clk(clk), .en(en), .a(s1), .b(dl3[9]), .y(s2));

    // first rounding stage: shift the significand to single position
    logic signed [11:0] se;
    logic signed [11:0] t;
    logic [5:0]         sh;
    logic [107:0]       wide;
    nar_t               nx;
    nar_t               nr;

    always_comb begin
      se = s2.exp + 12'sd127;
      t  = 12'sd30 - se;
      if (se >= 12'sd1) begin
        sh = 6'd29;
      end else if (t > 12'sd55) begin
        sh = 6'd55;
      end else begin
        sh = t[5:0];
      end
      wide    = {s2.man, 55'd0} >> sh;
      nx.nan  = s2.nan;
      nx.inf  = s2.inf;
      nx.zero = s2.zero;
      nx.sign = s2.sign;
      nx.se   = se;
      nx.q    = wide[78:55];
      nx.g    = wide[54];
      nx.st   = |wide[53:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nr <= nx;
      end
    end

    // second rounding stage: nearest even, overflow to infinity
    logic        up;
    logic [24:0] q25;
    logic [31:0] fin;

    always_comb begin
      up  = nr.g & (nr.st | nr.q[0]);
      q25 = {1'b0, nr.q} + {24'd0, up};
      if (nr.nan) begin
        fin = QNAN;
      end else if (nr.inf) begin
        fin = {nr.sign, 8'hFF, 23'd0};
      end else if (nr.zero) begin
        fin = {nr.sign, 31'd0};
      end else if (nr.se >= 12'sd1) begin
        if (q25[24]) begin
          fin = (nr.se >= 12'sd254) ? {nr.sign, 8'hFF, 23'd0}
                                    : {nr.sign, 8'(nr.se + 12'sd1), 23'd0};
        end else begin
          fin = (nr.se >= 12'sd255) ? {nr.sign, 8'hFF, 23'd0}
                                    : {nr.sign, nr.se[7:0], q25[22:0]};
        end
      end else begin
        fin = {nr.sign, 6'd0, q25};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res[r] <= fin;
      end
    end
  end

  assign out_0 = res[0];
  assign out_1 = res[1];
  assign out_2 = res[2];
  assign out_3 = res[3];

endmodule

@@ hdl/mv4_dadd.sv @@
// ----------------------------------------------------------------------------
// mv4_dadd: pipelined double-precision adder on unpacked operands
// Five stages: order, align, add, normalise, round to nearest even.
// ----------------------------------------------------------------------------
module mv4_dadd
  import mv4_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  dnum_t a,
  input  dnum_t b,
  output dnum_t y
);

  // stage a: special cases, operand order, exponent difference
  logic        a_big;
  dnum_t       big;
  dnum_t       sml;
  dnum_t       sv;
  logic        spec;
  logic [11:0] diff;

  always_comb begin
    a_big = (a.exp > b.exp) || ((a.exp == b.exp) && (a.man >= b.man));
    big   = a_big ? a : b;
    sml   = a_big ? b : a;
    diff  = 12'(big.exp - sml.exp);
    spec  = a.nan | b.nan | a.inf | b.inf | a.zero | b.zero;
    sv    = a;
    if (a.nan || b.nan || (a.inf && b.inf && (a.sign ^ b.sign))) begin
      sv     = '0;
      sv.nan = 1'b1;
    end else if (a.inf) begin
      sv = a;
    end else if (b.inf) begin
      sv = b;
    end else if (a.zero && b.zero) begin
      sv      = '0;
      sv.zero = 1'b1;
      sv.sign = a.sign & b.sign;
    end else if (a.zero) begin
      sv = b;
    end
  end

  logic               sa_spec;
  dnum_t              sa_sv;
  logic               sa_sign;
  logic               sa_sub;
  logic signed [11:0] sa_exp;
  logic [52:0]        sa_mb;
  logic [52:0]        sa_ms;
  logic [5:0]         sa_sh;

  always_ff @(posedge clk) begin
    if (en) begin
      sa_spec <= spec;
      sa_sv   <= sv;
      sa_sign <= big.sign;
      sa_sub  <= a.sign ^ b.sign;
      sa_exp  <= big.exp;
      sa_mb   <= big.man;
      sa_ms   <= sml.man;
      sa_sh   <= (diff > 12'd63) ? 6'd63 : diff[5:0];
    end
  end

  // stage b: align the smaller operand, keeping guard, round and sticky
  logic [111:0] wide;
  logic [55:0]  aligned;

  always_comb begin
    wide    = {sa_ms, 3'd0, 56'd0} >> sa_sh;
    aligned = {wide[111:57], wide[56] | (|wide[55:0])};
  end

  logic               sb_spec;
  dnum_t              sb_sv;
  logic               sb_sign;
  logic               sb_sub;
  logic signed [11:0] sb_exp;
  logic [55:0]        sb_big;
  logic [55:0]        sb_al;

  always_ff @(posedge clk) begin
    if (en) begin
      sb_spec <= sa_spec;
      sb_sv   <= sa_sv;
      sb_sign <= sa_sign;
      sb_sub  <= sa_sub;
      sb_exp  <= sa_exp;
      sb_big  <= {sa_mb, 3'd0};
      sb_al   <= aligned;
    end
  end

  // stage c: magnitude add or subtract
  logic               sc_spec;
  dnum_t              sc_sv;
  logic               sc_sign;
  logic signed [11:0] sc_exp;
  logic [56:0]        sc_sum;

  always_ff @(posedge clk) begin
    if (en) begin
      sc_spec <= sb_spec;
      sc_sv   <= sb_sv;
      sc_sign <= sb_sign;
      sc_exp  <= sb_exp;
      sc_sum  <= sb_sub ? ({1'b0, sb_big} - {1'b0, sb_al})
                        : ({1'b0, sb_big} + {1'b0, sb_al});
    end
  end

  // stage d: normalise so the leading one sits at bit 55
  logic [5:0]         lz;
  logic [55:0]        norm;
  logic signed [11:0] nexp;

  always_comb begin
    lz = lzc56(sc_sum[55:0]);
    if (sc_sum[56]) begin
      norm = {sc_sum[56:2], sc_sum[1] | sc_sum[0]};
      nexp = sc_exp + 12'sd1;
    end else begin
      norm = sc_sum[55:0] << lz;
      nexp = sc_exp - $signed({6'd0, lz});
    end
  end

  logic               sd_spec;
  dnum_t              sd_sv;
  logic               sd_sign;
  logic               sd_zero;
  logic signed [11:0] sd_exp;
  logic [55:0]        sd_n;

  always_ff @(posedge clk) begin
    if (en) begin
      sd_spec <= sc_spec;
      sd_sv   <= sc_sv;
      sd_sign <= sc_sign;
      sd_zero <= (sc_sum == 57'd0);
      sd_exp  <= nexp;
      sd_n    <= norm;
    end
  end

  // stage e: round to 53 bits, nearest even
  logic        up;
  logic [53:0] m54;
  dnum_t       rnd;

  always_comb begin
    up  = sd_n[2] & ((|sd_n[1:0]) | sd_n[3]);
    m54 = {1'b0, sd_n[55:3]} + {53'd0, up};
    rnd = '0;
    if (sd_spec) begin
      rnd = sd_sv;
    end else if (sd_zero) begin
      rnd.zero = 1'b1;
    end else begin
      rnd.sign = sd_sign;
      if (m54[53]) begin
        rnd.man = m54[53:1];
        rnd.exp = sd_exp + 12'sd1;
      end else begin
        rnd.man = m54[52:0];
        rnd.exp = sd_exp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= rnd;
    end
  end

endmodule
